// ===== hdl/sctot_pkg.sv =====
package sctot_pkg;

  localparam int unsigned MaxTimers = 6;
  localparam int unsigned IrqW      = 6;

  localparam logic [31:0] SegMask   = 32'h1FFF_FFFF;
  localparam logic [15:0] ModeWMask = 16'h63FF;

  localparam logic [31:0] TimerBase [MaxTimers] = '{
    32'h1F80_1100, 32'h1F80_1110, 32'h1F80_1120,
    32'h1F80_1480, 32'h1F80_1490, 32'h1F80_14A0
  };

  // mode word bit positions
  localparam int unsigned ModeZeroRet = 3;
  localparam int unsigned ModeTgtIrq  = 4;
  localparam int unsigned ModeOvfIrq  = 5;
  localparam int unsigned ModeRepeat  = 6;
  localparam int unsigned ModeIrqEn   = 10;
  localparam int unsigned ModeTgtFlag = 11;
  localparam int unsigned ModeOvfFlag = 12;
  localparam int unsigned ModeStopped = 15;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_COUNT  = 2'd0,
    REG_MODE   = 2'd1,
    REG_TARGET = 2'd2
  } reg_sel_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TICK = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [31:0]     read_data;
    logic            hit;
    logic [IrqW-1:0] irq_lines;
  } out_t;

endpackage

// ===== hdl/sctot_addr_dec.sv =====
module sctot_addr_dec import sctot_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 6,
  parameter int unsigned IdxW       = 3
) (
  input  logic [31:0]     addr_i,
  output logic            hit_o,
  output logic [IdxW-1:0] idx_o,
  output reg_sel_e        sel_o
);

  logic [31:0] phys;
  logic        win_hit;
  logic        off_ok;

  assign phys = addr_i & SegMask;

  // windows are 16-byte aligned and disjoint, so any match is the only one
  always_comb begin
    win_hit = 1'b0;
    idx_o   = '0;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (phys[28:4] == TimerBase[k][28:4]) begin
        win_hit = 1'b1;
        idx_o   = IdxW'(k);
      end
    end
  end

  always_comb begin
    off_ok = 1'b1;
    sel_o  = REG_COUNT;
    case (phys[3:0])
      4'h0:    sel_o = REG_COUNT;
      4'h4:    sel_o = REG_MODE;
      4'h8:    sel_o = REG_TARGET;
      default: off_ok = 1'b0;
    endcase
  end

  assign hit_o = win_hit & off_ok;

endmodule

// ===== hdl/sctot_tick_unit.sv =====
module sctot_tick_unit import sctot_pkg::*; (
  input  logic [31:0] cnt_i,
  input  logic [15:0] mode_i,
  input  logic [31:0] tgt_i,
  input  logic        narrow_i,
  output logic [31:0] cnt_o,
  output logic [15:0] mode_o,
  output logic        fire_o
);

  logic [32:0] cnt;
  logic [15:0] mode;
  logic        ovf;

  always_comb begin
    cnt    = {1'b0, cnt_i} + 33'd1;
    mode   = mode_i;
    fire_o = 1'b0;
    ovf    = 1'b0;
    if (!mode_i[ModeStopped]) begin
      // target match
      if (!mode[ModeTgtFlag] && (cnt >= {1'b0, tgt_i})) begin
        if (mode[ModeTgtIrq] && mode[ModeIrqEn]) begin
          fire_o = 1'b1;
          if (!mode[ModeRepeat]) mode[ModeIrqEn] = 1'b0;
        end
        if (mode[ModeZeroRet]) begin
          if (tgt_i != 32'd0) cnt = cnt - {1'b0, tgt_i};
          else                cnt = '0;
        end else begin
          mode[ModeTgtFlag] = 1'b1;
        end
      end
      // overflow past the limit
      ovf = narrow_i ? (cnt[32:16] != 17'd0) : cnt[32];
      if (ovf) begin
        if (mode[ModeOvfIrq] && mode[ModeIrqEn]) begin
          fire_o = 1'b1;
          if (!mode[ModeRepeat]) mode[ModeIrqEn] = 1'b0;
        end
        mode[ModeOvfFlag] = 1'b1;
        mode[ModeTgtFlag] = 1'b0;
        if (narrow_i) cnt = cnt - 33'h0_0001_0000;
        else          cnt[32] = 1'b0;
      end
      cnt_o  = cnt[31:0];
      mode_o = mode;
    end else begin
      cnt_o  = cnt_i;
      mode_o = mode_i;
    end
  end

endmodule

// ===== hdl/six_channel_target_overflow_timer.sv =====
// a register read or write gives its result from registers loaded at the accepting edge
// and the block stays ready, so bus beats can follow back to back
// a tick runs the shared tick unit over one timer per cycle, busy until the last timer,
// result strobed in the cycle after the last timer; the receiver cannot stall
// reset (async, active low) clears all counts, modes and targets and returns to idle
module six_channel_target_overflow_timer import sctot_pkg::*; #(
  parameter int unsigned NUM_TIMERS    = 6,
  parameter int unsigned NARROW_TIMERS = 3
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  in_i,
  output logic busy_o,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IrqW-1:0] irq_q, irq_d;
  out_t res_q, res_d;
  logic done_q, done_d;

  logic [31:0] cnt_q  [NUM_TIMERS];
  logic [15:0] mode_q [NUM_TIMERS];
  logic [31:0] tgt_q  [NUM_TIMERS];

  logic            accept;
  logic            dec_hit;
  logic [IdxW-1:0] dec_idx;
  reg_sel_e        dec_sel;
  logic [31:0]     rd_data;
  logic            bus_we;
  logic            tick_we;
  logic            last_timer;
  logic            narrow;
  logic [31:0]     cnt_new;
  logic [15:0]     mode_new;
  logic            fire;

  sctot_addr_dec #(
    .NUM_TIMERS(NUM_TIMERS),
    .IdxW      (IdxW)
  ) u_dec (
    .addr_i(in_i.address),
    .hit_o (dec_hit),
    .idx_o (dec_idx),
    .sel_o (dec_sel)
  );

  assign narrow = (32'(idx_q) < 32'(NARROW_TIMERS));

  sctot_tick_unit u_tick (
    .cnt_i   (cnt_q[idx_q]),
    .mode_i  (mode_q[idx_q]),
    .tgt_i   (tgt_q[idx_q]),
    .narrow_i(narrow),
    .cnt_o   (cnt_new),
    .mode_o  (mode_new),
    .fire_o  (fire)
  );

  assign accept     = start_i & ~busy_o;
  assign last_timer = (idx_q == IdxW'(NUM_TIMERS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op_e'(in_i.operation) == OP_TICK)) state_d = ST_TICK;
      end
      ST_TICK: begin
        if (last_timer) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy_o  = 1'b0;
    tick_we = 1'b0;
    case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_TICK: begin
        busy_o  = 1'b1;
        tick_we = 1'b1;
      end
      default: busy_o = 1'b0;
    endcase
  end

  always_comb begin
    rd_data = '0;
    if (dec_hit) begin
      case (dec_sel)
        REG_COUNT:  rd_data = cnt_q[dec_idx];
        REG_MODE:   rd_data = {16'd0, mode_q[dec_idx]};
        REG_TARGET: rd_data = tgt_q[dec_idx];
        default:    rd_data = '0;
      endcase
    end
  end

  always_comb begin
    res_d  = res_q;
    done_d = 1'b0;
    irq_d  = irq_q;
    idx_d  = idx_q;
    bus_we = 1'b0;
    if (accept) begin
      case (op_e'(in_i.operation))
        OP_READ: begin
          res_d  = '{read_data: rd_data, hit: dec_hit, irq_lines: '0};
          done_d = 1'b1;
        end
        OP_WRITE: begin
          res_d  = '{read_data: '0, hit: dec_hit, irq_lines: '0};
          done_d = 1'b1;
          bus_we = dec_hit;
        end
        OP_TICK: begin
          idx_d = '0;
          irq_d = '0;
        end
        default: begin
          res_d  = '0;
          done_d = 1'b1;
        end
      endcase
    end
    if (tick_we) begin
      irq_d = irq_q | (IrqW'(fire) << idx_q);
      idx_d = idx_q + IdxW'(1);
      if (last_timer) begin
        res_d  = '{read_data: '0, hit: 1'b0, irq_lines: irq_d};
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      irq_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      irq_q   <= irq_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // timer registers: bus writes only while idle, writeback only while ticking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        cnt_q[k]  <= '0;
        mode_q[k] <= '0;
        tgt_q[k]  <= '0;
      end
    end else if (bus_we) begin
      case (dec_sel)
        REG_COUNT: cnt_q[dec_idx] <= in_i.write_data;
        REG_MODE: begin
          mode_q[dec_idx] <= (in_i.write_data[15:0] & ModeWMask) | (16'd1 << ModeIrqEn);
          cnt_q[dec_idx]  <= '0;
        end
        REG_TARGET: tgt_q[dec_idx] <= in_i.write_data;
        default: ;
      endcase
    end else if (tick_we) begin
      cnt_q[idx_q]  <= cnt_new;
      mode_q[idx_q] <= mode_new;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while still ticking");

  a_irq_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.irq_lines != '0)) |-> $past(busy_o))
    else $error("interrupt lines set on a bus beat");

  a_hit_no_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.hit) |-> (result_o.irq_lines == '0))
    else $error("hit and interrupt lines in one result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (idx_q <= IdxW'(NUM_TIMERS - 1)))
    else $error("timer index out of range");

endmodule
